/* rtl/core/fmos_pkg.sv */
`timescale 1ns / 1ps

package fmos_pkg;

  // Table geometry
  localparam int GRID_MAX  = 1024;
  localparam int MODES_MAX = 8;
  localparam int GRID_W    = $clog2(GRID_MAX);
  localparam int MODE_W    = $clog2(MODES_MAX);

  // Register widths
  localparam int GCFG_W    = 11;
  localparam int MCFG_W    = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  // Arithmetic widths
  localparam int ENTRY_W   = 16;
  localparam int PROD_W    = 2 * ENTRY_W;
  localparam int PAIR_W    = 18;
  localparam int PQ_W      = 2 * PAIR_W;
  localparam int TERM_W    = PQ_W + 1;
  localparam int ACC_W     = 48;
  localparam int PIPE_STAGES = 6;

  // Stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 2 * ACC_W;

  // Command codes carried on in_tuser
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_POINTS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MODES       = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic capture;
    logic issue;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_err;
    logic grid_zero;
    logic last_issue;
    logic pipe_busy;
    logic out_full;
  } dp_status_t;

endpackage

/* rtl/core/four_mode_overlap_sum.sv */
`timescale 1ns / 1ps
// Load word: written to the table on acceptance; a new word may follow in the next cycle.
// Compute word: one grid point per cycle, set by one read of all mode banks per cycle,
//   then a six-stage multiply pipeline, and the sum is loaded into the output register.
// Index error or zero grid points: no grid points are issued and the zero sum goes straight to the output register.
// rst_n (synchronous) clears control and restores the registers; the table is not cleared.

module four_mode_overlap_sum
  import fmos_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // grid_index[9:0], mode_first[12:10], mode_second[15:13], mode_third[18:16],
  // mode_fourth[21:19], value_real[37:22], value_imag[53:38], zero pad[55:54]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[0]
  input  logic                  in_tuser,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // sum_real[47:0], sum_imag[95:48]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // index_error[0]
  output logic                  out_tuser
);

  logic [GCFG_W-1:0] grid_cfg_r;
  logic [MCFG_W-1:0] modes_cfg_r;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cfg_r  <= GCFG_W'(1024);
      modes_cfg_r <= MCFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_POINTS: grid_cfg_r  <= cfg_wdata[GCFG_W-1:0];
        REG_MODES:       modes_cfg_r <= cfg_wdata[MCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fmos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fmos_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .grid_cfg   (grid_cfg_r),
    .modes_cfg  (modes_cfg_r),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/core/fmos_ctrl.sv */
`timescale 1ns / 1ps

module fmos_ctrl
  import fmos_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tuser,
  output logic       in_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one word at a time: take loads while idle, compute over the grid
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.wr_en    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == CMD_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            if (status.idx_err || status.grid_zero) begin
              state_nxt = ST_FINISH;
            end else begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/fmos_dp.sv */
`timescale 1ns / 1ps

module fmos_dp
  import fmos_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [GCFG_W-1:0]     grid_cfg,
  input  logic [MCFG_W-1:0]     modes_cfg,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  // Unpack the input word
  logic [GRID_W-1:0]         in_grid;
  logic [MODE_W-1:0]         in_k, in_s, in_q, in_l;
  logic [2*ENTRY_W-1:0]      in_entry;
  assign in_grid  = in_tdata[9:0];
  assign in_k     = in_tdata[12:10];
  assign in_s     = in_tdata[15:13];
  assign in_q     = in_tdata[18:16];
  assign in_l     = in_tdata[21:19];
  assign in_entry = in_tdata[53:22];

  // Clamp the configuration
  logic [MCFG_W-1:0] m_eff;
  logic [GCFG_W-1:0] g_eff;
  assign m_eff = (modes_cfg > MCFG_W'(MODES_MAX)) ? MCFG_W'(MODES_MAX) : modes_cfg;
  assign g_eff = (grid_cfg > GCFG_W'(GRID_MAX)) ? GCFG_W'(GRID_MAX) : grid_cfg;

  assign status.idx_err = ({1'b0, in_k} >= m_eff) || ({1'b0, in_s} >= m_eff) ||
                          ({1'b0, in_q} >= m_eff) || ({1'b0, in_l} >= m_eff);
  assign status.grid_zero = (g_eff == '0);

  // Capture modes and error flag for the running compute
  logic [MODE_W-1:0] k_r, s_r, q_r, l_r;
  logic              err_r;
  logic [GCFG_W-1:0] n_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      k_r   <= in_k;
      s_r   <= in_s;
      q_r   <= in_q;
      l_r   <= in_l;
      err_r <= status.idx_err;
    end
  end

  // Advance the grid address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (cmd.capture) begin
      n_r <= '0;
    end else if (cmd.issue) begin
      n_r <= n_r + 1'b1;
    end
  end

  assign status.last_issue = (n_r == g_eff - 1'b1);

  // One bank per mode; all banks read at the same grid point each cycle
  logic [2*ENTRY_W-1:0] rd_r [MODES_MAX];

  for (genvar b = 0; b < MODES_MAX; b++) begin : g_bank
    logic [2*ENTRY_W-1:0] mem [GRID_MAX];
    always_ff @(posedge clk) begin
      if (cmd.wr_en && in_k == MODE_W'(b)) begin
        mem[in_grid] <= in_entry;
      end
      rd_r[b] <= mem[n_r[GRID_W-1:0]];
    end
  end

  // Valid bits down the pipeline
  logic [PIPE_STAGES-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[PIPE_STAGES-2:0], cmd.issue};
    end
  end
  assign status.pipe_busy = |v_r;

  // Stage 2: pick the four entries
  logic signed [ENTRY_W-1:0] kr_r, ki_r, sr_r, si_r, qr_r, qi_r, lr_r, li_r;
  always_ff @(posedge clk) begin
    {ki_r, kr_r} <= rd_r[k_r];
    {si_r, sr_r} <= rd_r[s_r];
    {qi_r, qr_r} <= rd_r[q_r];
    {li_r, lr_r} <= rd_r[l_r];
  end

  // Stage 3: partial products of both pairs
  logic signed [PROD_W-1:0] a_rr_r, a_ii_r, a_ri_r, a_ir_r;
  logic signed [PROD_W-1:0] b_rr_r, b_ii_r, b_ri_r, b_ir_r;
  always_ff @(posedge clk) begin
    a_rr_r <= kr_r * sr_r;
    a_ii_r <= ki_r * si_r;
    a_ri_r <= kr_r * si_r;
    a_ir_r <= ki_r * sr_r;
    b_rr_r <= qr_r * lr_r;
    b_ii_r <= qi_r * li_r;
    b_ri_r <= qr_r * li_r;
    b_ir_r <= qi_r * lr_r;
  end

  // Stage 4: pair products, floor-shifted to 15 fraction bits
  logic signed [PROD_W:0]   p_re_w, p_im_w, q_re_w, q_im_w;
  logic signed [PAIR_W-1:0] pr_r, pi_r, qr2_r, qi2_r;
  assign p_re_w = {a_rr_r[PROD_W-1], a_rr_r} - {a_ii_r[PROD_W-1], a_ii_r};
  assign p_im_w = {a_ri_r[PROD_W-1], a_ri_r} + {a_ir_r[PROD_W-1], a_ir_r};
  assign q_re_w = {b_rr_r[PROD_W-1], b_rr_r} - {b_ii_r[PROD_W-1], b_ii_r};
  assign q_im_w = {b_ri_r[PROD_W-1], b_ri_r} + {b_ir_r[PROD_W-1], b_ir_r};
  always_ff @(posedge clk) begin
    pr_r  <= p_re_w[PROD_W:15];
    pi_r  <= p_im_w[PROD_W:15];
    qr2_r <= q_re_w[PROD_W:15];
    qi2_r <= q_im_w[PROD_W:15];
  end

  // Stage 5: conj(P) * Q partial products
  logic signed [PQ_W-1:0] rr_r, ii_r, ri_r, ir_r;
  always_ff @(posedge clk) begin
    rr_r <= pr_r * qr2_r;
    ii_r <= pi_r * qi2_r;
    ri_r <= pr_r * qi2_r;
    ir_r <= pi_r * qr2_r;
  end

  // Stage 6: combine into one complex term
  logic signed [TERM_W-1:0] t_re_r, t_im_r;
  always_ff @(posedge clk) begin
    t_re_r <= {rr_r[PQ_W-1], rr_r} + {ii_r[PQ_W-1], ii_r};
    t_im_r <= {ri_r[PQ_W-1], ri_r} - {ir_r[PQ_W-1], ir_r};
  end

  // Accumulate, wrapping at 48 bits
  logic [ACC_W-1:0] acc_re_r, acc_im_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v_r[PIPE_STAGES-1]) begin
      acc_re_r <= acc_re_r + {{(ACC_W-TERM_W){t_re_r[TERM_W-1]}}, t_re_r};
      acc_im_r <= acc_im_r + {{(ACC_W-TERM_W){t_im_r[TERM_W-1]}}, t_im_r};
    end
  end

  // Output register: holds a result while the next word is taken
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= {acc_im_r, acc_re_r};
      out_tuser <= err_r;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign status.out_full = out_valid_r && !out_tready;

endmodule
